// ----- sv/i2c_register_master_top_assert.svh -----
// ----------------------------------------------------------------------------
// I2C register master assertion macros
// Shared concurrent assertion forms for the I2C register master.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_MASTER_TOP_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define I2CRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define I2CRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/i2crm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register master package
// Types, constants and codes shared by the I2C register master modules.
// ----------------------------------------------------------------------------
`default_nettype none
package i2crm_pkg;

    localparam int unsigned BufDepth = 256;
    localparam int unsigned BufAw    = 8;
    localparam int unsigned CntW     = 9;

    localparam logic [9:0] HalfPeriodRst = 10'd15;
    localparam logic [9:0] AckWaitRst    = 10'd500;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_LOAD  = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BUSY   = 2'd1,
        ST_NOACK  = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        STG_ADDR  = 2'd0,
        STG_REG   = 2'd1,
        STG_DATA  = 2'd2,
        STG_RADDR = 2'd3
    } t_stage;

    localparam int unsigned RegHalf = 0;
    localparam int unsigned RegAck  = 1;

    typedef enum logic [15:0] {
        PH_IDLE = 16'h0001,
        PH_ST1  = 16'h0002,
        PH_ST2  = 16'h0004,
        PH_ST3  = 16'h0008,
        PH_ST4  = 16'h0010,
        PH_SBH  = 16'h0020,
        PH_SBL  = 16'h0040,
        PH_AKP  = 16'h0080,
        PH_AKH  = 16'h0100,
        PH_AKL  = 16'h0200,
        PH_RBH  = 16'h0400,
        PH_RBL  = 16'h0800,
        PH_KAH  = 16'h1000,
        PH_KAL  = 16'h2000,
        PH_SP1  = 16'h4000,
        PH_SP2  = 16'h8000
    } t_phase;

    typedef struct packed {
        logic [7:0] write_byte;
        logic [7:0] byte_count;
        logic [7:0] register_address;
        logic [7:0] device_address;
        logic       sda_in;
        t_kind      kind;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic       done_res;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       sda_release;
        logic       scl_level;
    } t_result;

    typedef struct packed {
        logic [9:0] half_period_ticks;
        logic [9:0] ack_wait_limit;
    } t_cfg;

endpackage
`default_nettype wire

// ----- sv/i2c_register_master_top.sv -----
// ----------------------------------------------------------------------------
// I2C register master top level
// Stream command/tick input, stream result output, APB configuration.
// ----------------------------------------------------------------------------
// An item taken on the slave side passes the queue stage, then the result
// register, before its result reaches the master side; one item per cycle while
// the master side is ready. The bit engine handles one item per cycle unless
// stalled; the two-entry queue and the result register let either side stall independently.
// Reset (synchronous, active low) idles the engine with SCL and SDA released,
// clears the write buffer valid bits and restores the registers to 15 and 500.
`default_nettype none
module i2c_register_master_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] sda_in, [8:1] device_address, [16:9] register_address,
    // [24:17] byte_count, [32:25] write_byte, [39:33] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] scl_level, [1] sda_release, [9:2] read_byte, [10] read_valid,
    // [11] busy_res, [12] done_res, [14:13] status, [15] zero
    output logic [15:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    i2crm_pkg::t_cfg    r_cfg;
    logic               w_q_valid, w_q_pop, w_wr;
    i2crm_pkg::t_item   w_q_item;
    i2crm_pkg::t_result w_res;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= i2crm_pkg::HalfPeriodRst;
            r_cfg.ack_wait_limit    <= i2crm_pkg::AckWaitRst;
        end else if (w_wr) begin
            if (paddr == 3'(4 * i2crm_pkg::RegHalf)) r_cfg.half_period_ticks <= pwdata[9:0];
            if (paddr == 3'(4 * i2crm_pkg::RegAck))  r_cfg.ack_wait_limit    <= pwdata[9:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == 3'(4 * i2crm_pkg::RegHalf)) prdata = {22'd0, r_cfg.half_period_ticks};
        else if (paddr == 3'(4 * i2crm_pkg::RegAck)) prdata = {22'd0, r_cfg.ack_wait_limit};
    end

    i2crm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    i2crm_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (w_res)
    );

    assign m_axis_tdata = {1'b0, w_res};

endmodule
`default_nettype wire

// ----- sv/i2crm_front.sv -----
// ----------------------------------------------------------------------------
// I2C register master front end
// Accepts stream items, decodes them and queues them for the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none
module i2crm_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [39:0]     i_data,
    input  wire logic [1:0]      i_user,
    output logic                 o_q_valid,
    output i2crm_pkg::t_item     o_q_item,
    input  wire logic            i_q_pop
);

    i2crm_pkg::t_item r_q [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    i2crm_pkg::t_item w_item;
    logic             w_push;

    always_comb begin
        w_item.kind             = i2crm_pkg::t_kind'(i_user);
        w_item.sda_in           = i_data[0];
        w_item.device_address   = i_data[8:1];
        w_item.register_address = i_data[16:9];
        w_item.byte_count       = i_data[24:17];
        w_item.write_byte       = i_data[32:25];
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ (i_q_pop && o_q_valid);
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop && o_q_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/i2crm_engine.sv -----
// ----------------------------------------------------------------------------
// I2C register master bit engine
// Runs START, byte send, ACK poll, byte receive and STOP; holds write buffer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_register_master_top_assert.svh"
module i2crm_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire i2crm_pkg::t_cfg   i_cfg,
    input  wire logic              i_q_valid,
    input  wire i2crm_pkg::t_item  i_q_item,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output i2crm_pkg::t_result     o_res
);

    i2crm_pkg::t_phase r_phase, n_phase;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_is_read, n_is_read;
    i2crm_pkg::t_stage r_stage, n_stage;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_shreg, n_shreg;
    logic [3:0]  r_bitn, n_bitn;
    logic [9:0]  r_ticks, n_ticks;
    logic [9:0]  r_polls, n_polls;
    i2crm_pkg::t_status r_err, n_err;
    logic [i2crm_pkg::CntW-1:0] r_load_cnt, n_load_cnt;

    logic [7:0]  r_mem [i2crm_pkg::BufDepth];
    logic [i2crm_pkg::BufDepth-1:0] r_mvalid;
    logic [7:0]  r_rdata;
    logic        r_rdv;
    logic [7:0]  w_wbyte;

    logic        r_out_valid;
    i2crm_pkg::t_result r_out;
    i2crm_pkg::t_result w_res;

    logic        w_step, w_load;
    logic [9:0]  w_hp, w_lim;
    logic [10:0] w_tick1, w_poll1;
    logic        f_send, f_stop, f_recv, f_start;
    logic [7:0]  f_byte;
    logic [7:0]  w_sh_rx;
    logic [3:0]  w_bit1;
    logic [7:0]  w_idx1;
    logic        o_rv, o_dn;
    i2crm_pkg::t_status o_st;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign w_step  = o_q_pop;
    assign w_hp    = (i_cfg.half_period_ticks == 10'd0) ? 10'd1 : i_cfg.half_period_ticks;
    assign w_lim   = (i_cfg.ack_wait_limit == 10'd0) ? 10'd1 : i_cfg.ack_wait_limit;
    assign w_tick1 = {1'b0, r_ticks} + 11'd1;
    assign w_poll1 = {1'b0, r_polls} + 11'd1;
    assign w_sh_rx = {r_shreg[6:0], i_q_item.sda_in};
    assign w_bit1  = r_bitn + 4'd1;
    assign w_idx1  = r_idx + 8'd1;
    assign w_wbyte = r_rdv ? r_rdata : 8'h00;
    assign w_load  = w_step && (i_q_item.kind == i2crm_pkg::K_LOAD) &&
                     (r_phase == i2crm_pkg::PH_IDLE) &&
                     (r_load_cnt < i2crm_pkg::CntW'(i2crm_pkg::BufDepth));

    always_comb begin
        n_phase = r_phase;  n_scl = r_scl;  n_sda = r_sda;
        n_is_read = r_is_read;  n_stage = r_stage;
        n_dev = r_dev;  n_reg = r_reg;  n_count = r_count;  n_idx = r_idx;
        n_shreg = r_shreg;  n_bitn = r_bitn;  n_ticks = r_ticks;
        n_polls = r_polls;  n_err = r_err;  n_load_cnt = r_load_cnt;
        f_send = 1'b0;  f_stop = 1'b0;  f_recv = 1'b0;  f_start = 1'b0;
        f_byte = 8'h00;
        o_rv = 1'b0;  o_dn = 1'b0;  o_st = i2crm_pkg::ST_OK;

        if (w_step) begin
            if (i_q_item.kind == i2crm_pkg::K_TICK) begin
                if (r_phase == i2crm_pkg::PH_AKP) begin
                    if (!i_q_item.sda_in) begin
                        n_phase = i2crm_pkg::PH_AKH;
                        n_ticks = 10'd0;
                    end else begin
                        n_polls = w_poll1[9:0];
                        if (w_poll1 >= {1'b0, w_lim}) begin
                            n_err  = i2crm_pkg::ST_NOACK;
                            f_stop = 1'b1;
                        end
                    end
                end else if (r_phase != i2crm_pkg::PH_IDLE) begin
                    if (w_tick1 < {1'b0, w_hp}) begin
                        n_ticks = w_tick1[9:0];
                    end else begin
                        n_ticks = 10'd0;
                        unique case (r_phase)
                            i2crm_pkg::PH_ST1: begin
                                n_scl = 1'b1;  n_phase = i2crm_pkg::PH_ST2;
                            end
                            i2crm_pkg::PH_ST2: begin
                                if (!i_q_item.sda_in) begin
                                    n_err = i2crm_pkg::ST_BUSY;  f_stop = 1'b1;
                                end else begin
                                    n_sda = 1'b0;  n_phase = i2crm_pkg::PH_ST3;
                                end
                            end
                            i2crm_pkg::PH_ST3: begin
                                n_scl = 1'b0;  n_phase = i2crm_pkg::PH_ST4;
                            end
                            i2crm_pkg::PH_ST4: begin
                                f_send = 1'b1;
                                if (r_stage == i2crm_pkg::STG_RADDR) begin
                                    f_byte = r_dev + 8'd1;
                                end else begin
                                    n_stage = i2crm_pkg::STG_ADDR;  f_byte = r_dev;
                                end
                            end
                            i2crm_pkg::PH_SBH: begin
                                n_scl = 1'b0;  n_phase = i2crm_pkg::PH_SBL;
                            end
                            i2crm_pkg::PH_SBL: begin
                                n_shreg = {r_shreg[6:0], 1'b0};
                                n_bitn  = w_bit1;
                                n_scl   = 1'b1;
                                if (w_bit1 < 4'd8) begin
                                    n_sda = r_shreg[6];  n_phase = i2crm_pkg::PH_SBH;
                                end else begin
                                    n_sda = 1'b1;  n_polls = 10'd0;
                                    n_phase = i2crm_pkg::PH_AKP;
                                end
                            end
                            i2crm_pkg::PH_AKH: begin
                                n_scl = 1'b0;  n_phase = i2crm_pkg::PH_AKL;
                            end
                            i2crm_pkg::PH_AKL: begin
                                if (r_stage == i2crm_pkg::STG_ADDR) begin
                                    n_stage = i2crm_pkg::STG_REG;
                                    f_send = 1'b1;  f_byte = r_reg;
                                end else if (r_stage == i2crm_pkg::STG_RADDR) begin
                                    if (r_count == 8'd0) f_stop = 1'b1;
                                    else f_recv = 1'b1;
                                end else if (r_is_read) begin
                                    n_stage = i2crm_pkg::STG_RADDR;  f_start = 1'b1;
                                end else if (r_idx < r_count) begin
                                    // buffer byte was prefetched at address r_idx
                                    n_idx = w_idx1;  n_stage = i2crm_pkg::STG_DATA;
                                    f_send = 1'b1;  f_byte = w_wbyte;
                                end else begin
                                    f_stop = 1'b1;
                                end
                            end
                            i2crm_pkg::PH_RBH: begin
                                n_shreg = w_sh_rx;  n_bitn = w_bit1;
                                if (w_bit1 >= 4'd8) o_rv = 1'b1;
                                n_scl = 1'b0;  n_phase = i2crm_pkg::PH_RBL;
                            end
                            i2crm_pkg::PH_RBL: begin
                                n_scl = 1'b1;
                                if (r_bitn < 4'd8) begin
                                    n_phase = i2crm_pkg::PH_RBH;
                                end else begin
                                    n_idx = w_idx1;
                                    n_sda = (w_idx1 >= r_count);
                                    n_phase = i2crm_pkg::PH_KAH;
                                end
                            end
                            i2crm_pkg::PH_KAH: begin
                                n_scl = 1'b0;  n_phase = i2crm_pkg::PH_KAL;
                            end
                            i2crm_pkg::PH_KAL: begin
                                if (r_idx < r_count) f_recv = 1'b1;
                                else f_stop = 1'b1;
                            end
                            i2crm_pkg::PH_SP1: begin
                                n_scl = 1'b1;  n_phase = i2crm_pkg::PH_SP2;
                            end
                            i2crm_pkg::PH_SP2: begin
                                n_sda = 1'b1;  n_phase = i2crm_pkg::PH_IDLE;
                                o_dn = 1'b1;  o_st = r_err;
                            end
                            default: begin
                                n_phase = i2crm_pkg::PH_IDLE;  n_scl = 1'b1;  n_sda = 1'b1;
                            end
                        endcase
                    end
                end
            end else if (r_phase == i2crm_pkg::PH_IDLE) begin
                if (i_q_item.kind == i2crm_pkg::K_LOAD) begin
                    if (w_load) n_load_cnt = r_load_cnt + i2crm_pkg::CntW'(1);
                end else begin
                    n_dev     = i_q_item.device_address;
                    n_reg     = i_q_item.register_address;
                    n_count   = i_q_item.byte_count;
                    n_is_read = (i_q_item.kind == i2crm_pkg::K_READ);
                    if (i_q_item.kind != i2crm_pkg::K_READ) n_load_cnt = '0;
                    n_idx   = 8'd0;
                    n_err   = i2crm_pkg::ST_OK;
                    n_stage = i2crm_pkg::STG_ADDR;
                    f_start = 1'b1;
                end
            end
        end

        if (f_send) begin
            n_shreg = f_byte;  n_bitn = 4'd0;  n_scl = 1'b1;  n_sda = f_byte[7];
            n_phase = i2crm_pkg::PH_SBH;  n_ticks = 10'd0;
        end
        if (f_stop) begin
            n_sda = 1'b0;  n_scl = 1'b0;  n_phase = i2crm_pkg::PH_SP1;  n_ticks = 10'd0;
        end
        if (f_recv) begin
            n_sda = 1'b1;  n_scl = 1'b1;  n_shreg = 8'h00;  n_bitn = 4'd0;
            n_phase = i2crm_pkg::PH_RBH;  n_ticks = 10'd0;
        end
        if (f_start) begin
            n_sda = 1'b1;  n_phase = i2crm_pkg::PH_ST1;  n_ticks = 10'd0;
        end
    end

    always_comb begin
        w_res.scl_level   = n_scl;
        w_res.sda_release = n_sda;
        w_res.read_valid  = o_rv;
        w_res.read_byte   = o_rv ? w_sh_rx : 8'h00;
        w_res.busy_res    = (n_phase != i2crm_pkg::PH_IDLE);
        w_res.done_res    = o_dn;
        w_res.status      = o_dn ? o_st : i2crm_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2crm_pkg::PH_IDLE;
            r_scl <= 1'b1;  r_sda <= 1'b1;
            r_is_read <= 1'b0;  r_stage <= i2crm_pkg::STG_ADDR;
            r_dev <= 8'd0;  r_reg <= 8'd0;  r_count <= 8'd0;  r_idx <= 8'd0;
            r_shreg <= 8'd0;  r_bitn <= 4'd0;  r_ticks <= 10'd0;  r_polls <= 10'd0;
            r_err <= i2crm_pkg::ST_OK;  r_load_cnt <= '0;
            r_mvalid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_scl <= n_scl;  r_sda <= n_sda;
            r_is_read <= n_is_read;  r_stage <= n_stage;
            r_dev <= n_dev;  r_reg <= n_reg;  r_count <= n_count;  r_idx <= n_idx;
            r_shreg <= n_shreg;  r_bitn <= n_bitn;  r_ticks <= n_ticks;
            r_polls <= n_polls;  r_err <= n_err;  r_load_cnt <= n_load_cnt;
            if (w_load) r_mvalid[r_load_cnt[i2crm_pkg::BufAw-1:0]] <= 1'b1;
            if (w_step) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_mem[r_load_cnt[i2crm_pkg::BufAw-1:0]] <= i_q_item.write_byte;
        r_rdata <= r_mem[r_idx];
        r_rdv   <= r_mvalid[r_idx];
        if (w_step) r_out <= w_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `I2CRM_ASSERT_IMP(a_idle_released, i_clk, i_rst_n, r_phase == i2crm_pkg::PH_IDLE,
        r_scl && r_sda, "bus not released while idle")
    `I2CRM_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res,
        !r_out.busy_res, "done reported while still busy")
    `I2CRM_ASSERT_IMP(a_read_busy, i_clk, i_rst_n, r_out_valid && r_out.read_valid,
        r_out.busy_res, "read byte outside a transaction")
    `I2CRM_ASSERT_IMP(a_status_done, i_clk, i_rst_n,
        r_out_valid && (r_out.status != i2crm_pkg::ST_OK), r_out.done_res,
        "status without done")
    `I2CRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_ready,
        r_out_valid, "result dropped while stalled")

endmodule
`default_nettype wire
